FILE: rtl/core/spe_pkg.sv
// ----------------------------------------------------------------------------
// spe_pkg: shared types and constants of the stack pattern eraser
// Request and response layouts, command codes, register indexes and the
// pattern character lookup.
// ----------------------------------------------------------------------------
package spe_pkg;

   localparam int STACK_DEPTH_DEFAULT = 4096;
   localparam int MAX_PATTERN_DEFAULT = 32;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PATTERN_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PATTERN_WORD_0 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PATTERN_WORD_1 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PATTERN_WORD_2 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PATTERN_WORD_3 = 3'd4;

   typedef enum logic [1:0] {
      CMD_FEED  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  in_char;
      logic [11:0] read_index;
   } req_type;

   typedef struct packed {
      logic        removed;
      logic [12:0] depth;
      logic [7:0]  read_char;
      logic        overflow;
      logic        is_empty;
   } rsp_type;

   typedef logic [3:0][63:0] pattern_type;

   function automatic logic [7:0] pattern_char(input pattern_type words,
                                               input logic [4:0] k);
      return words[k[4:3]][{k[2:0], 3'b000} +: 8];
   endfunction

endpackage

FILE: rtl/core/stack_pattern_eraser.sv
// ----------------------------------------------------------------------------
// stack_pattern_eraser: cascading pattern removal over a byte stack
// A request is taken when start is high and busy is low. It feeds a byte,
// reads a kept byte at a position counted from the bottom, or clears the
// stack. Every request gives exactly one response, shown on rsp_data for a
// single cycle with rsp_valid high; the receiver cannot hold it off.
// A fed byte that needs no pattern check, a clear and an unused command
// respond one cycle after acceptance and busy stays low, so a request may
// be taken in every cycle. A read within the depth waits in the read state
// for the stack memory and keeps busy high until it responds; a read beyond
// it responds like a clear, with a zero character. A fed byte equal to the
// last pattern character, with a pattern longer than one byte and enough
// kept bytes below it, starts a check: the stored bytes are fetched one per
// cycle through the single read port of the stack memory and checked by one
// byte comparator. A mismatch ends the check early. The pattern registers
// should be written through the csr port only while the block is idle; the
// block itself does not enforce this. Reset empties the stack and restores
// pattern length one and a zero pattern; the stack memory is not cleared.
// ----------------------------------------------------------------------------
module stack_pattern_eraser
   import spe_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT,
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int IW = (AW > 12) ? AW : 12;
   localparam int CW = (DW > 12) ? DW : 12;
   localparam int OW = (DW > 13) ? DW : 13;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ
   } state_type;

   state_type   state_ff, state_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [DW-1:0] base_ff, base_in;
   logic [4:0]  rest_ff, rest_in;
   logic [4:0]  j_ff, j_in;
   logic [4:0]  cmp_idx_ff, cmp_idx_in;
   logic        cmp_valid_ff, cmp_valid_in;
   logic [7:0]  feed_char_ff, feed_char_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   pattern_type pattern_ff;
   logic [5:0]  pattern_length_ff;

   logic [7:0]  mem [STACK_DEPTH];
   logic [7:0]  rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic        mem_we;
   logic [7:0]  mem_wdata;

   logic [5:0]  len_eff;
   logic [4:0]  rest_eff;
   logic        last_hit;
   logic        idx_in_range;
   logic [IW-1:0] idx_wide;
   logic [DW-1:0] scan_sum;
   logic [OW-1:0] depth_wide;
   logic        full;
   logic        push_go;
   logic        respond;
   logic        removed_v;
   logic        overflow_v;
   logic [7:0]  rchar_v;

   assign len_eff = (pattern_length_ff == 6'd0) ? 6'd1 :
                    (pattern_length_ff > 6'(MAX_PATTERN)) ? 6'(MAX_PATTERN) :
                    pattern_length_ff;
   assign rest_eff = 5'(len_eff - 6'd1);
   assign last_hit = (req_data.in_char == pattern_char(pattern_ff, rest_eff)) &&
                     (depth_ff >= DW'(rest_eff));
   assign idx_wide = IW'(req_data.read_index);
   assign idx_in_range = CW'(req_data.read_index) < CW'(depth_ff);
   assign scan_sum = base_ff + DW'(j_ff);
   assign full = depth_ff >= DW'(STACK_DEPTH);

   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      base_in      = base_ff;
      rest_in      = rest_ff;
      j_in         = j_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_valid_in = 1'b0;
      feed_char_in = feed_char_ff;
      rd_addr      = '0;
      push_go      = 1'b0;
      respond      = 1'b0;
      removed_v    = 1'b0;
      overflow_v   = 1'b0;
      rchar_v      = 8'd0;
      mem_we       = 1'b0;
      mem_wdata    = feed_char_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               feed_char_in = req_data.in_char;
               mem_wdata    = req_data.in_char;
               case (req_data.cmd)
                  CMD_FEED: begin
                     if (last_hit && rest_eff == 5'd0) begin
                        removed_v = 1'b1;
                        respond   = 1'b1;
                     end else if (last_hit) begin
                        state_in = ST_SCAN;
                        j_in     = 5'd0;
                        base_in  = depth_ff - DW'(rest_eff);
                        rest_in  = rest_eff;
                     end else begin
                        push_go = 1'b1;
                        respond = 1'b1;
                     end
                  end
                  CMD_READ: begin
                     if (idx_in_range) begin
                        rd_addr  = idx_wide[AW-1:0];
                        state_in = ST_READ;
                     end else begin
                        respond = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     depth_in = '0;
                     respond  = 1'b1;
                  end
                  default: begin
                     respond = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (j_ff < rest_ff) begin
               rd_addr      = scan_sum[AW-1:0];
               j_in         = j_ff + 5'd1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = j_ff;
            end
            if (cmp_valid_ff) begin
               if (rd_data_ff != pattern_char(pattern_ff, cmp_idx_ff)) begin
                  push_go  = 1'b1;
                  respond  = 1'b1;
                  state_in = ST_IDLE;
               end else if (cmp_idx_ff == rest_ff - 5'd1) begin
                  depth_in  = depth_ff - DW'(rest_ff);
                  removed_v = 1'b1;
                  respond   = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         ST_READ: begin
            rchar_v  = rd_data_ff;
            respond  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (push_go) begin
         if (full) begin
            overflow_v = 1'b1;
         end else begin
            mem_we   = 1'b1;
            depth_in = depth_ff + DW'(1);
         end
      end

      depth_wide         = OW'(depth_in);
      rsp_valid_in       = respond;
      rsp_in             = rsp_ff;
      if (respond) begin
         rsp_in.removed   = removed_v;
         rsp_in.depth     = depth_wide[12:0];
         rsp_in.read_char = rchar_v;
         rsp_in.overflow  = overflow_v;
         rsp_in.is_empty  = (depth_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[depth_ff[AW-1:0]] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         depth_ff          <= '0;
         cmp_valid_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         pattern_length_ff <= 6'd1;
         pattern_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_PATTERN_LENGTH: pattern_length_ff <= csr_wdata[5:0];
               REG_PATTERN_WORD_0: pattern_ff[0] <= csr_wdata;
               REG_PATTERN_WORD_1: pattern_ff[1] <= csr_wdata;
               REG_PATTERN_WORD_2: pattern_ff[2] <= csr_wdata;
               REG_PATTERN_WORD_3: pattern_ff[3] <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      base_ff      <= base_in;
      rest_ff      <= rest_in;
      j_ff         <= j_in;
      cmp_idx_ff   <= cmp_idx_in;
      feed_char_ff <= feed_char_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(STACK_DEPTH))
      else $error("Stack depth exceeds the memory size.");

   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !full)
      else $error("Push written into a full stack.");

   a_removed_excludes_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.removed && rsp_data.overflow))
      else $error("Response flags both removal and overflow.");

   a_response_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start || busy))
      else $error("Response without an accepted request.");

   a_scan_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && cmp_valid_ff) |-> (cmp_idx_ff < rest_ff))
      else $error("Compare index beyond the pattern prefix.");
`endif

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the stack pattern eraser
// A falling-edge driver feeds the request backlog, with random gaps at times.
// A rising-edge monitor predicts every accepted request in the bench's own
// model of the stack and checks each response, field by field, in order.
// Pattern lengths run from the shortest to the longest, including values
// that saturate. Random well-formed and broken pattern streams exercise
// cascaded removal, reads, clears and the unused command.
// ----------------------------------------------------------------------------
module tb;
   import spe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_SIZE    = STACK_DEPTH_DEFAULT;
   localparam int PATTERN_MAX   = MAX_PATTERN_DEFAULT;
   localparam int CYCLE_LIMIT   = 4000000;
   localparam int SETTLE_CYCLES = 40;
   localparam int WORD_RANDOM   = 0;
   localparam int WORD_PAIR     = 1;
   localparam int WORD_SAME     = 2;
   localparam int IDLE_NONE     = 0;
   localparam int IDLE_MIXED    = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPARE = REG_PATTERN_WORD_3 + 3'd1;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   req_type                    req_data = '0;
   logic                       rsp_valid;
   rsp_type                    rsp_data;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   stack_pattern_eraser dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Bench copy of the block state and its registers.
   logic [7:0]  kept_mem [STACK_SIZE];
   int          kept_count = 0;
   logic [5:0]  len_reg = 6'd1;
   logic [63:0] pat_words [4] = '{default: '0};

   req_type     req_backlog [$];
   rsp_type     awaited_rsp [$];
   int          added_items = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          gap_left = 0;
   int          idle_style = IDLE_NONE;
   bit          req_taken = 1'b0;

   function automatic int eff_len();
      if (len_reg == 6'd0) return 1;
      if (len_reg > PATTERN_MAX) return PATTERN_MAX;
      return int'(len_reg);
   endfunction

   function automatic logic [7:0] pat_byte(int k);
      return pat_words[k >> 3][(k & 7) * 8 +: 8];
   endfunction

   function automatic rsp_type predict_erase(req_type r);
      rsp_type o;
      int      rest;
      int      base;
      int      j;
      bit      hit;
      o = '0;
      case (r.cmd)
         CMD_FEED: begin
            rest = eff_len() - 1;
            hit = 1'b0;
            if (r.in_char == pat_byte(rest) && kept_count >= rest) begin
               hit = 1'b1;
               base = kept_count - rest;
               for (j = 0; j < rest; j++) begin
                  if (kept_mem[base + j] != pat_byte(j)) hit = 1'b0;
               end
            end
            if (hit) begin
               kept_count -= rest;
               o.removed = 1'b1;
            end else if (kept_count >= STACK_SIZE) begin
               o.overflow = 1'b1;
            end else begin
               kept_mem[kept_count] = r.in_char;
               kept_count++;
            end
         end
         CMD_READ: begin
            if (int'(r.read_index) < kept_count) o.read_char = kept_mem[r.read_index];
         end
         CMD_CLEAR: begin
            kept_count = 0;
         end
         default: ;
      endcase
      o.depth = 13'(kept_count);
      o.is_empty = (kept_count == 0);
      return o;
   endfunction

   function automatic int pick_gap();
      int r;
      if (idle_style == IDLE_NONE) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(30, 120);
   endfunction

   task automatic report_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Driver: a new request goes out once the previous one has been taken.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (req_backlog.size() != 0) begin
            req_data <= req_backlog.pop_front();
            start <= 1'b1;
            gap_left <= pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: check the response first, then predict a request taken now.
   always @(posedge clock) begin
      rsp_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         req_taken = !reset && start && !busy;
         if (!reset && rsp_valid) begin
            if (awaited_rsp.size() == 0) begin
               $display("%0t: response with no request waiting, actual %p", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = awaited_rsp.pop_front();
               report_field("removed", want.removed, rsp_data.removed);
               report_field("depth", want.depth, rsp_data.depth);
               report_field("read_char", want.read_char, rsp_data.read_char);
               report_field("overflow", want.overflow, rsp_data.overflow);
               report_field("is_empty", want.is_empty, rsp_data.is_empty);
            end
         end
         if (req_taken) awaited_rsp.push_back(predict_erase(req_data));
      end
   end

   task automatic push_req(cmd_type c, logic [7:0] ch, logic [11:0] idx);
      req_type r;
      r.cmd = c;
      r.in_char = ch;
      r.read_index = idx;
      req_backlog.push_back(r);
      added_items++;
   endtask

   task automatic feed(logic [7:0] ch);
      push_req(CMD_FEED, ch, 12'($urandom));
   endtask

   task automatic read_at(logic [11:0] idx);
      push_req(CMD_READ, 8'($urandom), idx);
   endtask

   task automatic csr_write(logic [CSR_INDEX_WIDTH-1:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_PATTERN_LENGTH: len_reg = val[5:0];
         REG_PATTERN_WORD_0: pat_words[0] = val;
         REG_PATTERN_WORD_1: pat_words[1] = val;
         REG_PATTERN_WORD_2: pat_words[2] = val;
         REG_PATTERN_WORD_3: pat_words[3] = val;
         default: ;
      endcase
   endtask

   task automatic configure(logic [5:0] len, logic [63:0] w0, logic [63:0] w1,
                            logic [63:0] w2, logic [63:0] w3);
      logic [63:0] len_word;
      len_word = {$urandom, $urandom};
      len_word[5:0] = len;
      csr_write(REG_PATTERN_LENGTH, len_word);
      csr_write(REG_PATTERN_WORD_0, w0);
      csr_write(REG_PATTERN_WORD_1, w1);
      csr_write(REG_PATTERN_WORD_2, w2);
      csr_write(REG_PATTERN_WORD_3, w3);
      if ($urandom_range(0, 1))
         csr_write(REG_SPARE + 3'($urandom_range(0, 2)), {$urandom, $urandom});
   endtask

   function automatic logic [63:0] pattern_word(int style);
      logic [63:0] w;
      int          k;
      for (k = 0; k < 8; k++) begin
         case (style)
            WORD_PAIR: w[k * 8 +: 8] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
            WORD_SAME: w[k * 8 +: 8] = 8'h7e;
            default:   w[k * 8 +: 8] = 8'($urandom);
         endcase
      end
      return w;
   endfunction

   task automatic configure_styled(logic [5:0] len, int style);
      configure(len, pattern_word(style), pattern_word(style), pattern_word(style),
                pattern_word(style));
   endtask

   task automatic drain();
      while (req_backlog.size() != 0 || start || awaited_rsp.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // A whole pattern, possibly with another one nested inside it, and
   // possibly with one character spoiled.
   task automatic emit_pattern(int nest, bit spoil);
      int len;
      int split;
      int bad;
      int k;
      len = eff_len();
      split = $urandom_range(0, len - 1);
      bad = spoil ? $urandom_range(0, len - 1) : -1;
      for (k = 0; k < len; k++) begin
         if (nest > 0 && k == split) emit_pattern(nest - 1, 1'b0);
         feed((k == bad) ? 8'($urandom) : pat_byte(k));
      end
   endtask

   task automatic random_phase(int count);
      int first;
      int r;
      int k;
      int n;
      first = added_items;
      while (added_items - first < count) begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            emit_pattern($urandom_range(0, 2), 1'b0);
         end else if (r < 38) begin
            emit_pattern($urandom_range(0, 1), 1'b1);
         end else if (r < 50) begin
            n = (eff_len() > 1) ? $urandom_range(1, eff_len() - 1) : 1;
            for (k = 0; k < n; k++) feed(pat_byte(k));
         end else if (r < 62) begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++)
               feed($urandom_range(0, 1) ? pat_byte($urandom_range(0, eff_len() - 1))
                                         : 8'($urandom));
         end else if (r < 70) begin
            feed(pat_byte(eff_len() - 1));
         end else if (r < 84) begin
            k = $urandom_range(0, 99);
            if (k < 60) read_at(12'($urandom_range(0, 15)));
            else if (k < 85) read_at(12'($urandom_range(0, 255)));
            else read_at(12'($urandom));
         end else if (r < 88) begin
            push_req(CMD_CLEAR, 8'($urandom), 12'($urandom));
         end else if (r < 91) begin
            push_req(CMD_NOP, 8'($urandom), 12'($urandom));
         end else begin
            feed(8'($urandom));
         end
      end
   endtask

   initial begin
      logic [7:0] p [4];
      int         k;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Reset values: a one-character pattern of zero.
      idle_style = IDLE_MIXED;
      feed(8'h00);
      feed(8'hff);
      feed(8'h00);
      read_at(12'd0);
      read_at(12'd1);
      read_at(12'hfff);
      push_req(CMD_NOP, 8'hff, 12'hfff);
      push_req(CMD_CLEAR, 8'h00, 12'h000);
      feed(8'h00);
      drain();

      configure_styled(6'd4, WORD_RANDOM);
      for (k = 0; k < 4; k++) p[k] = pat_byte(k);
      feed(p[3]);
      push_req(CMD_CLEAR, 8'($urandom), 12'($urandom));
      for (k = 0; k < 4; k++) feed(p[k]);
      feed(p[0]);
      feed(p[1]);
      for (k = 0; k < 4; k++) feed(p[k]);
      feed(p[2]);
      feed(p[3]);
      feed(p[0]);
      feed(p[1]);
      feed(p[2]);
      feed(p[3] ^ 8'h01);
      feed(p[3]);
      read_at(12'd0);
      read_at(12'd3);
      read_at(12'd5);
      push_req(CMD_NOP, 8'($urandom), 12'($urandom));
      push_req(CMD_CLEAR, 8'($urandom), 12'($urandom));
      drain();

      idle_style = IDLE_MIXED;
      configure_styled(6'd2, WORD_RANDOM);
      random_phase(120);
      drain();
      idle_style = IDLE_NONE;
      configure_styled(6'd3, WORD_PAIR);
      random_phase(120);
      drain();
      idle_style = IDLE_MIXED;
      configure_styled(6'd1, WORD_RANDOM);
      random_phase(120);
      drain();
      configure_styled(6'd4, WORD_SAME);
      random_phase(120);
      drain();
      idle_style = IDLE_NONE;
      configure_styled(6'd5, WORD_RANDOM);
      random_phase(120);
      drain();
      idle_style = IDLE_MIXED;
      configure_styled(6'd8, WORD_PAIR);
      random_phase(120);
      drain();
      configure_styled(6'd31, WORD_RANDOM);
      random_phase(120);
      drain();
      idle_style = IDLE_NONE;
      configure_styled(6'd32, WORD_RANDOM);
      random_phase(120);
      drain();
      idle_style = IDLE_MIXED;
      configure_styled(6'd0, WORD_RANDOM);
      random_phase(120);
      drain();
      configure(6'd63, '1, '1, '1, '1);
      random_phase(120);
      drain();
      idle_style = IDLE_NONE;
      configure_styled(6'd12, WORD_PAIR);
      random_phase(120);
      drain();
      idle_style = IDLE_MIXED;
      configure_styled(6'd17, WORD_RANDOM);
      random_phase(120);
      drain();

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
